// ===== rtl/core/ffoa_pkg.sv =====
// ---------------------------------------------------------------------------
// ffoa_pkg
// Shared types for the first-fit offset allocator: item structs, cell
// commands and cell status flags.
// ---------------------------------------------------------------------------
package ffoa_pkg;

	typedef enum logic [0:0] {
		ACT_ALLOC = 1'b0,
		ACT_FREE  = 1'b1
	} action_t;

	typedef struct packed {
		logic        action;
		logic [31:0] region_addr;
		logic [31:0] region_size;
	} in_item_t;

	typedef struct packed {
		logic [31:0] result_addr;
		logic [31:0] in_use;
		logic [31:0] high_water;
		logic        status;
	} out_item_t;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_SPLIT,
		CMD_REMOVE,
		CMD_MERGE_BOTH,
		CMD_GROW_PREV,
		CMD_GROW_NEXT,
		CMD_INSERT
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     here;       // cell is the target position
		logic     below;      // cell sits just below the target
		logic     from_right; // cell takes its right neighbour
		logic     from_left;  // cell takes its left neighbour
	} cell_ctl_t;

	typedef struct packed {
		logic fit;   // length covers the request
		logic lt;    // start below the freed address
		logic touch; // hole ends exactly at the freed address
		logic eqend; // hole starts exactly at the end of the freed region
	} cell_flags_t;

	localparam logic [0:0] REG_ALIGN_LOG2 = 1'b0;
	localparam logic [2:0] ALIGN_RESET    = 3'd3;

endpackage

// ===== rtl/core/ffoa_cell.sv =====
// ---------------------------------------------------------------------------
// ffoa_cell
// One entry of the address-sorted hole table. Reports its compare flags and
// moves, splits or grows its hole under a broadcast command.
// ---------------------------------------------------------------------------
module ffoa_cell #(
	parameter int ADDR_BITS = 32
) (
	input  logic                   clk,
	input  ffoa_pkg::cell_ctl_t    ctl,
	input  logic [ADDR_BITS-1:0]   req_addr,
	input  logic [ADDR_BITS-1:0]   req_size,
	input  logic [ADDR_BITS-1:0]   req_end,
	input  logic [ADDR_BITS-1:0]   left_start,
	input  logic [ADDR_BITS-1:0]   left_len,
	input  logic [ADDR_BITS-1:0]   right_start,
	input  logic [ADDR_BITS-1:0]   right_len,
	output logic [ADDR_BITS-1:0]   hole_start,
	output logic [ADDR_BITS-1:0]   hole_len,
	output ffoa_pkg::cell_flags_t  flags
);
	import ffoa_pkg::*;

	logic [ADDR_BITS-1:0] start_q;
	logic [ADDR_BITS-1:0] len_q;
	logic [ADDR_BITS-1:0] hole_top;

	assign hole_start  = start_q;
	assign hole_len    = len_q;
	assign hole_top    = start_q + len_q;
	assign flags.fit   = (len_q >= req_size);
	assign flags.lt    = (start_q < req_addr);
	assign flags.touch = (hole_top == req_addr);
	assign flags.eqend = (start_q == req_end);

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			CMD_SPLIT: begin
				if (ctl.here) begin
					start_q <= start_q + req_size;
					len_q   <= len_q - req_size;
				end
			end
			CMD_REMOVE: begin
				if (ctl.from_right) begin
					start_q <= right_start;
					len_q   <= right_len;
				end
			end
			CMD_MERGE_BOTH: begin
				if (ctl.below) begin
					len_q <= len_q + req_size + right_len;
				end else if (ctl.from_right) begin
					start_q <= right_start;
					len_q   <= right_len;
				end
			end
			CMD_GROW_PREV: begin
				if (ctl.below) begin
					len_q <= len_q + req_size;
				end
			end
			CMD_GROW_NEXT: begin
				if (ctl.here) begin
					start_q <= req_addr;
					len_q   <= len_q + req_size;
				end
			end
			CMD_INSERT: begin
				if (ctl.here) begin
					start_q <= req_addr;
					len_q   <= req_size;
				end else if (ctl.from_left) begin
					start_q <= left_start;
					len_q   <= left_len;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/core/first_fit_offset_allocator.sv =====
// ---------------------------------------------------------------------------
// first_fit_offset_allocator
// First-fit offset allocator with a coalescing, address-sorted hole table.
//
// Input items (in_valid/in_ready, in_item) ask to allocate a size or to free
// a region; each gives exactly one result item (out_valid/out_ready,
// out_item) with the offset, bytes in use, the peak and a table-full status.
// align_log2 is written through the APB port at address 0; the user must
// write it only while idle, which the block does not enforce. An item whose
// size rounds to zero goes from ST_PREP straight to ST_FINISH; others pass
// ST_PREP, ST_SCAN and ST_FINISH, the scan visiting one hole cell per cycle
// up to the hole count, at most MAX_HOLES; all cells move the table at once.
// Items are taken one at a time; a new item is accepted while the previous
// result still waits in the output register. If the receiver stalls, the
// next result is held until that register drains.
// Reset empties the table, zeroes heap end, in-use and peak, and sets
// align_log2 to 3; no clearing pass is needed.
// ---------------------------------------------------------------------------
module first_fit_offset_allocator #(
	parameter int MAX_HOLES = 16,
	parameter int ADDR_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ffoa_pkg::in_item_t   in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ffoa_pkg::out_item_t  out_item,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	import ffoa_pkg::*;

	localparam int CW = $clog2(MAX_HOLES + 1);
	localparam int IW = $clog2(MAX_HOLES);
	localparam int SW = (ADDR_BITS > 33) ? ADDR_BITS : 33;
	localparam int XW = (ADDR_BITS > 32) ? ADDR_BITS : 32;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t               state_q;
	logic [2:0]           align_q;
	logic                 action_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic [ADDR_BITS-1:0] size_q;
	logic [ADDR_BITS-1:0] end_q;
	logic [ADDR_BITS-1:0] heap_q;
	logic [ADDR_BITS-1:0] used_q;
	logic [ADDR_BITS-1:0] high_q;
	logic [ADDR_BITS-1:0] res_q;
	logic                 status_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        scan_q;
	cell_op_t             cmd_op_q;
	logic [CW-1:0]        cmd_pos_q;
	logic [CW-1:0]        cmd_cnt_q;
	logic                 out_valid_q;
	out_item_t            out_item_q;

	logic [ADDR_BITS-1:0] c_start [MAX_HOLES];
	logic [ADDR_BITS-1:0] c_len   [MAX_HOLES];
	cell_flags_t          c_flags [MAX_HOLES];
	logic [MAX_HOLES-1:0] fit_v, lt_v, touch_v, eqend_v;

	logic [7:0]           step_mask;
	logic [32:0]          size_sum;
	logic [SW-1:0]        size_rnd;
	logic [XW-1:0]        addr_ext;
	logic [ADDR_BITS:0]   used_add;
	logic [ADDR_BITS-1:0] hw_next;
	logic                 at_end;
	logic [IW-1:0]        idx;
	logic [IW-1:0]        idx_m1;
	logic                 join_prev, join_next;

	// alignment rounding
	assign step_mask = 8'((9'd1 << align_q) - 9'd1);
	assign size_sum  = 33'(in_item.region_size) + 33'(step_mask);
	assign size_rnd  = (in_item.region_size == 32'd0) ? '0 :
		SW'(size_sum & ~33'(step_mask));
	assign addr_ext  = XW'(in_item.region_addr);

	assign used_add  = {1'b0, used_q} + {1'b0, size_q};
	assign hw_next   = (used_q > high_q) ? used_q : high_q;

	assign at_end    = (scan_q == count_q);
	assign idx       = scan_q[IW-1:0];
	assign idx_m1    = IW'(scan_q - CW'(1));
	assign join_prev = (scan_q != '0) && touch_v[idx_m1];
	assign join_next = !at_end && eqend_v[idx];

	generate
		for (genvar k = 0; k < MAX_HOLES; k++) begin : g_cell
			cell_ctl_t            ctl;
			logic [ADDR_BITS-1:0] l_start, l_len, r_start, r_len;

			assign ctl.op         = cmd_op_q;
			assign ctl.here       = (int'(cmd_pos_q) == k);
			assign ctl.below      = (int'(cmd_pos_q) == k + 1);
			assign ctl.from_right = (k >= int'(cmd_pos_q)) && (k + 1 < int'(cmd_cnt_q));
			assign ctl.from_left  = (k > int'(cmd_pos_q)) && (k <= int'(cmd_cnt_q));

			if (k == 0) begin : g_first
				assign l_start = '0;
				assign l_len   = '0;
			end else begin : g_mid
				assign l_start = c_start[k-1];
				assign l_len   = c_len[k-1];
			end
			if (k == MAX_HOLES - 1) begin : g_last
				assign r_start = '0;
				assign r_len   = '0;
			end else begin : g_inner
				assign r_start = c_start[k+1];
				assign r_len   = c_len[k+1];
			end

			ffoa_cell #(
				.ADDR_BITS(ADDR_BITS)
			) u_cell (
				.clk        (clk),
				.ctl        (ctl),
				.req_addr   (addr_q),
				.req_size   (size_q),
				.req_end    (end_q),
				.left_start (l_start),
				.left_len   (l_len),
				.right_start(r_start),
				.right_len  (r_len),
				.hole_start (c_start[k]),
				.hole_len   (c_len[k]),
				.flags      (c_flags[k])
			);

			assign fit_v[k]   = c_flags[k].fit;
			assign lt_v[k]    = c_flags[k].lt;
			assign touch_v[k] = c_flags[k].touch;
			assign eqend_v[k] = c_flags[k].eqend;
		end
	endgenerate

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;
	assign pready    = 1'b1;
	assign prdata    = (paddr[2] == REG_ALIGN_LOG2) ? {29'd0, align_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			align_q <= ALIGN_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_ALIGN_LOG2) begin
			align_q <= pwdata[2:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			heap_q      <= '0;
			used_q      <= '0;
			high_q      <= '0;
			cmd_op_q    <= CMD_NONE;
			cmd_pos_q   <= '0;
			cmd_cnt_q   <= '0;
			scan_q      <= '0;
			out_valid_q <= 1'b0;
			action_q    <= 1'b0;
			addr_q      <= '0;
			size_q      <= '0;
			end_q       <= '0;
			res_q       <= '0;
			status_q    <= 1'b0;
			out_item_q  <= '0;
		end else begin
			// a command is issued only from the scan, and lasts one cycle
			if (state_q != ST_SCAN) begin
				cmd_op_q <= CMD_NONE;
			end
			if (out_valid_q && out_ready && state_q != ST_FINISH) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						action_q <= in_item.action;
						addr_q   <= addr_ext[ADDR_BITS-1:0];
						size_q   <= size_rnd[ADDR_BITS-1:0];
						state_q  <= ST_PREP;
					end
				end
				ST_PREP: begin
					end_q    <= addr_q + size_q;
					scan_q   <= '0;
					status_q <= 1'b0;
					if (size_q == '0) begin
						res_q   <= (action_q == ACT_ALLOC) ? heap_q : '0;
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (action_q == ACT_ALLOC) begin
						if (at_end || fit_v[idx]) begin
							used_q  <= used_add[ADDR_BITS] ? '1 : used_add[ADDR_BITS-1:0];
							state_q <= ST_FINISH;
							if (at_end) begin
								res_q  <= heap_q;
								heap_q <= heap_q + size_q;
							end else begin
								res_q     <= c_start[idx];
								cmd_pos_q <= scan_q;
								cmd_cnt_q <= count_q;
								if (c_len[idx] == size_q) begin
									cmd_op_q <= CMD_REMOVE;
									count_q  <= count_q - CW'(1);
								end else begin
									cmd_op_q <= CMD_SPLIT;
								end
							end
						end else begin
							scan_q <= scan_q + CW'(1);
						end
					end else begin
						if (at_end || !lt_v[idx]) begin
							res_q     <= '0;
							used_q    <= (size_q > used_q) ? '0 : used_q - size_q;
							cmd_pos_q <= scan_q;
							cmd_cnt_q <= count_q;
							state_q   <= ST_FINISH;
							if (join_prev && join_next) begin
								cmd_op_q <= CMD_MERGE_BOTH;
								count_q  <= count_q - CW'(1);
							end else if (join_prev) begin
								cmd_op_q <= CMD_GROW_PREV;
							end else if (join_next) begin
								cmd_op_q <= CMD_GROW_NEXT;
							end else if (int'(count_q) >= MAX_HOLES) begin
								status_q <= 1'b1;
							end else begin
								cmd_op_q <= CMD_INSERT;
								count_q  <= count_q + CW'(1);
							end
						end else begin
							scan_q <= scan_q + CW'(1);
						end
					end
				end
				ST_FINISH: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q            <= 1'b1;
						out_item_q.result_addr <= 32'(res_q);
						out_item_q.in_use      <= 32'(used_q);
						out_item_q.high_water  <= 32'(hw_next);
						out_item_q.status      <= status_q;
						high_q                 <= hw_next;
						state_q                <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= MAX_HOLES)
		else $error("hole count beyond table depth");

	a_peak_covers_use: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> high_q >= used_q)
		else $error("peak below bytes in use");

	a_cmd_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_op_q != CMD_NONE |-> state_q == ST_FINISH)
		else $error("table command outside finish");

	a_status_on_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FINISH && status_q |-> action_q == ACT_FREE)
		else $error("table-full status on allocate");

endmodule

// ===== sim/ffoa_checker.sv =====
// ---------------------------------------------------------------------------
// ffoa_checker
// Watches the request and result channels of the first-fit offset allocator,
// keeps its own hole table, heap end, in-use and peak, predicts one result
// per accepted request and compares each accepted result field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffoa_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  ffoa_pkg::in_item_t  in_item,
	input  logic                out_valid,
	input  logic                out_ready,
	input  ffoa_pkg::out_item_t out_item,
	input  logic [2:0]          align_log2,
	output int                  fail_count,
	output int                  pending
);
	import ffoa_pkg::*;

	localparam int HOLES = 16;

	logic [31:0] hstart [HOLES];
	logic [31:0] hlen   [HOLES];
	int          hcount;
	logic [31:0] heap_top;
	logic [31:0] bytes_used;
	logic [31:0] peak_used;
	out_item_t   expected_q[$];

	initial begin
		fail_count = 0;
		hcount     = 0;
		heap_top   = '0;
		bytes_used = '0;
		peak_used  = '0;
	end

	assign pending = expected_q.size();

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t mismatch %s: got %h want %h", $time, what, got, want);
		fail_count++;
	endtask

	function automatic logic [31:0] aligned(input logic [31:0] sz);
		logic [32:0] s;
		s = {1'b0, sz} + ((33'd1 << align_log2) - 33'd1);
		s = (s >> align_log2) << align_log2;
		return (sz == 0) ? 32'd0 : s[31:0];
	endfunction

	function automatic void drop_hole(input int i);
		for (int k = i; k + 1 < hcount; k++) begin
			hstart[k] = hstart[k + 1];
			hlen[k]   = hlen[k + 1];
		end
		hcount--;
	endfunction

	function automatic void charge(input logic [31:0] sz);
		if ({1'b0, sz} + {1'b0, bytes_used} > 33'hFFFF_FFFF) bytes_used = '1;
		else bytes_used = bytes_used + sz;
		if (bytes_used > peak_used) peak_used = bytes_used;
	endfunction

	function automatic out_item_t serve(input in_item_t req);
		out_item_t r;
		logic [31:0] sz, at, fin;
		int pos;
		bit lo, hi, found;
		r  = '0;
		sz = aligned(req.region_size);
		if (action_t'(req.action) == ACT_ALLOC) begin
			if (sz == 0) begin
				r.result_addr = heap_top;
			end else begin
				found = 0;
				for (int i = 0; i < hcount && !found; i++) begin
					if (hlen[i] >= sz) begin
						found = 1;
						at = hstart[i];
						if (hlen[i] > sz) begin
							hstart[i] = hstart[i] + sz;
							hlen[i]   = hlen[i] - sz;
						end else drop_hole(i);
					end
				end
				if (!found) begin
					at = heap_top;
					heap_top = heap_top + sz;
				end
				charge(sz);
				r.result_addr = at;
			end
		end else if (sz != 0) begin
			bytes_used = (sz > bytes_used) ? 32'd0 : bytes_used - sz;
			fin = req.region_addr + sz;
			pos = 0;
			while (pos < hcount && hstart[pos] < req.region_addr) pos++;
			lo = pos > 0 && (hstart[pos - 1] + hlen[pos - 1]) == req.region_addr;
			hi = pos < hcount && hstart[pos] == fin;
			if (lo && hi) begin
				hlen[pos - 1] = hlen[pos - 1] + sz + hlen[pos];
				drop_hole(pos);
			end else if (lo) begin
				hlen[pos - 1] = hlen[pos - 1] + sz;
			end else if (hi) begin
				hstart[pos] = req.region_addr;
				hlen[pos]   = hlen[pos] + sz;
			end else if (hcount >= HOLES) begin
				r.status = 1'b1;
			end else begin
				for (int k = hcount; k > pos; k--) begin
					hstart[k] = hstart[k - 1];
					hlen[k]   = hlen[k - 1];
				end
				hstart[pos] = req.region_addr;
				hlen[pos]   = sz;
				hcount++;
			end
		end
		r.in_use     = bytes_used;
		r.high_water = peak_used;
		return r;
	endfunction

	always @(posedge clk) begin
		out_item_t w;
		if (arst_n && in_valid && in_ready) expected_q.push_back(serve(in_item));
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				report("unexpected item", out_item.result_addr, '0);
			end else begin
				w = expected_q.pop_front();
				if (out_item.result_addr !== w.result_addr)
					report("result_addr", out_item.result_addr, w.result_addr);
				if (out_item.in_use !== w.in_use) report("in_use", out_item.in_use, w.in_use);
				if (out_item.high_water !== w.high_water)
					report("high_water", out_item.high_water, w.high_water);
				if (out_item.status !== w.status)
					report("status", {31'd0, out_item.status}, {31'd0, w.status});
			end
		end
	end

endmodule

// ===== sim/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Stimulus for the first-fit offset allocator: directed corner requests, then
// phases of random allocate/free traffic under several alignments, with
// random gaps on both channels. The checker predicts and compares.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import ffoa_pkg::*;

	localparam int STALL_LIMIT = 2000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	in_item_t    in_item = '0;
	logic        out_valid;
	logic        out_ready = 0;
	out_item_t   out_item;
	logic        psel = 0, penable = 0, pwrite = 0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic [2:0]  align_now = ALIGN_RESET;
	int          fail_count, pending, idle_cycles = 0;
	logic [31:0] live_addr[$];
	logic [31:0] live_size[$];
	logic [31:0] last_alloc_addr = '0;

	always #1 clk = ~clk;

	first_fit_offset_allocator i_dut (.*);

	ffoa_checker i_chk (
		.clk, .arst_n, .in_valid, .in_ready, .in_item, .out_valid, .out_ready,
		.out_item, .align_log2(align_now), .fail_count, .pending
	);

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	always begin
		@(negedge clk);
		out_ready <= 1'b0;
		repeat ($urandom_range(0, 11)) @(negedge clk);
		out_ready <= 1'b1;
		@(posedge clk);
		while (!out_valid) @(posedge clk);
	end

	always @(posedge clk)
		if (out_valid && out_ready) last_alloc_addr <= out_item.result_addr;

	function automatic logic [31:0] i_chk_last_addr();
		return last_alloc_addr;
	endfunction

	task automatic write_align(input logic [2:0] v);
		@(negedge clk);
		psel <= 1; pwrite <= 1; paddr <= {REG_ALIGN_LOG2, 2'b00}; pwdata <= {29'd0, v};
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		align_now = v;
	endtask

	task automatic request(input action_t act, input logic [31:0] a, input logic [31:0] s,
			input bit gaps);
		if (gaps) repeat ($urandom_range(0, 11)) @(negedge clk);
		@(negedge clk);
		in_valid <= 1;
		in_item  <= '{action: act, region_addr: a, region_size: s};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		in_valid <= 0;
	endtask

	task automatic drain;
		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic traffic(input int n);
		logic [31:0] sz, ad;
		int i;
		for (int j = 0; j < n; j++) begin
			sz = $urandom_range(0, 9) == 0 ? $urandom() : $urandom_range(0, 300);
			if ($urandom_range(0, 19) == 0) begin
				request(action_t'($urandom_range(0, 1)), $urandom(), sz, j % 7 != 0);
			end else if (live_addr.size() > 0 && $urandom_range(0, 1)) begin
				i = $urandom_range(0, live_addr.size() - 1);
				request(ACT_FREE, live_addr[i], live_size[i], j % 7 != 0);
				live_addr.delete(i);
				live_size.delete(i);
			end else begin
				request(ACT_ALLOC, $urandom(), sz, j % 7 != 0);
				while (pending != 0) @(posedge clk);
				@(negedge clk);
				live_addr.push_back(i_chk_last_addr());
				live_size.push_back(sz);
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		request(ACT_ALLOC, '0, '0, 0);
		request(ACT_FREE, '0, '0, 0);
		request(ACT_ALLOC, 32'hFFFF_FFFF, 32'h1, 0);
		request(ACT_ALLOC, '0, 32'd100, 0);
		request(ACT_FREE, 32'd8, 32'd16, 0);
		request(ACT_FREE, 32'd24, 32'd8, 0);
		request(ACT_FREE, 32'd0, 32'd8, 0);
		request(ACT_ALLOC, '0, 32'd40, 0);
		request(ACT_FREE, 32'd200, 32'hFFFF_FFFF, 0);
		request(ACT_ALLOC, '0, 32'hFFFF_FFF9, 0);
		request(ACT_ALLOC, '0, 32'hFFFF_FFFF, 0);
		for (int k = 0; k < 18; k++) request(ACT_FREE, 32'h1000 + 64 * k, 32'd8, 0);
		request(ACT_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
		drain();
		for (int ph = 0; ph < 8; ph++) begin
			write_align(ph == 0 ? 3'd0 : ph == 1 ? 3'd7 : 3'($urandom_range(0, 7)));
			traffic(75);
			drain();
		end
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
